>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ABKF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition is followed by another one on the next edge.
`define ABKF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/abkf_pkg.sv
package abkf_pkg;

	localparam int DATA_W  = 32;
	localparam int DT_W    = 24;
	localparam int DT_FRAC = 24;
	localparam int CFG_W   = 31;
	localparam int MUL_W   = 36;
	localparam int PROD_W  = 72;
	localparam int SUM_W   = 50;
	localparam int DEN_W   = 33;

	localparam logic OP_STEP   = 1'b0;
	localparam logic OP_PRESET = 1'b1;

	localparam logic [1:0] REG_Q_ANGLE = 2'd0;
	localparam logic [1:0] REG_Q_BIAS  = 2'd1;
	localparam logic [1:0] REG_R_NOISE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_WB,
		ST_DIV,
		ST_GAIN,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		P_DT_RATE,
		P_DT_P11,
		P_DT_INNER,
		P_DT_QBIAS,
		P_K0_Y,
		P_K1_Y,
		P_K0_P00,
		P_K0_P01,
		P_K1_P00,
		P_K1_P01
	} prod_t;

	typedef struct packed {
		logic  load;
		logic  preset;
		logic  mul;
		logic  wb;
		prod_t sel;
		logic  div_ld;
		logic  div_step;
		logic  gain_ld;
		logic  out_ld;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} status_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
		lo = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
		if (x > hi) begin
			return hi[DATA_W-1:0];
		end else if (x < lo) begin
			return lo[DATA_W-1:0];
		end
		return x[DATA_W-1:0];
	endfunction

	function automatic logic signed [SUM_W-1:0] sx(input logic [DATA_W-1:0] v);
		return {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
	endfunction

endpackage

>>> sv/angle_bias_kalman_filter.sv
// Two-state angle and gyro-bias Kalman filter, fixed point.
// Input stream (s_*): one transaction per sample. s_tuser is the opcode:
// 0 runs one predict/update step, 1 presets the angle to the measured angle.
// Output stream (m_*): one transaction per input, the filtered angle and the
// gyro rate minus the bias held before this step, both saturated Q16.16.
// Configuration channel (cfg_*): writes q_angle, q_bias and the measurement
// noise by index; it is always ready. Write it only while no step is in flight.
// One item is processed at a time. A filter step runs ten products on one
// shared 36x36 multiplier, each registered and then written back, and a
// radix-4 restoring division for both gains, run in two dividers that share
// the divisor. A preset goes from acceptance straight to the result state.
// The next input is accepted in the cycle after the result is loaded.
// The output register frees the result path: a finished result waits there
// while the receiver stalls, and the controller holds in its final state only
// when that register is still full. Reset clears the estimates and the
// covariance to zero and loads the noise registers with their defaults.
`include "assert_macros.svh"

module angle_bias_kalman_filter #(
	parameter int COV_FRAC_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,   // measured_angle[31:0], gyro_rate[63:32], time_step[87:64]
	input  logic        s_tuser,   // opcode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // filtered_angle[31:0], corrected_rate[63:32]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data
);
	import abkf_pkg::*;

	cmd_t    cmd;
	status_t status;
	logic    in_ready;
	logic [DATA_W-1:0] out_angle, out_rate;

	abkf_ctrl #(.COV_FRAC(COV_FRAC_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_opcode (s_tuser),
		.in_ready  (in_ready),
		.status    (status),
		.cmd       (cmd)
	);

	abkf_dp #(.COV_FRAC(COV_FRAC_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.meas      (s_tdata[31:0]),
		.gyro      (s_tdata[63:32]),
		.dt        (s_tdata[87:64]),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_angle (out_angle),
		.out_rate  (out_rate)
	);

	assign s_tready  = in_ready;
	assign cfg_ready = 1'b1;
	assign m_tdata   = {out_rate, out_angle};

	`ABKF_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready,
		"input accepted while a transaction is in flight")
	`ABKF_ASSERT(a_result_after_work, !$rose(m_tvalid) || $past(!s_tready),
		"result raised without a transaction in flight")
	`ABKF_ASSERT_NEXT(a_preset_done, s_tvalid && s_tready && s_tuser == OP_PRESET,
		!s_tready, "preset did not pass through the result state")

endmodule

>>> sv/abkf_div.sv
module abkf_div #(
	parameter int COV_FRAC = 24
) (
	input  logic                                 clk,
	input  logic                                 ld,
	input  logic                                 step,
	input  logic [31:0]                          num,
	input  logic [32:0]                          den,
	output logic [2*((32+COV_FRAC+1)/2)-1:0]     quo
);
	import abkf_pkg::*;

	localparam int NUM_W = 2*((32+COV_FRAC+1)/2);

	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] num_n;
	logic [NUM_W-1:0] quo_n;
	logic [DEN_W-1:0] rem_n;
	logic [DEN_W:0]   trial;

	always_comb begin
		num_n = num_q;
		quo_n = quo_q;
		rem_n = rem_q;
		trial = '0;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_n, num_n[NUM_W-1]};
			num_n = {num_n[NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_n = DEN_W'(trial - {1'b0, den_q});
				quo_n = {quo_n[NUM_W-2:0], 1'b1};
			end else begin
				rem_n = trial[DEN_W-1:0];
				quo_n = {quo_n[NUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			num_q <= NUM_W'({num, {COV_FRAC{1'b0}}});
			quo_q <= '0;
			rem_q <= '0;
			den_q <= den;
		end else if (step) begin
			num_q <= num_n;
			quo_q <= quo_n;
			rem_q <= rem_n;
		end
	end

	assign quo = quo_q;

endmodule

>>> sv/abkf_dp.sv
module abkf_dp #(
	parameter int COV_FRAC = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  abkf_pkg::cmd_t        cmd,
	output abkf_pkg::status_t     status,
	input  logic [31:0]           meas,
	input  logic [31:0]           gyro,
	input  logic [23:0]           dt,
	input  logic                  cfg_valid,
	input  logic [1:0]            cfg_index,
	input  logic [30:0]           cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           out_angle,
	output logic [31:0]           out_rate
);
	import abkf_pkg::*;

	localparam int NUM_W = 2*((32+COV_FRAC+1)/2);
	localparam logic [CFG_W-1:0] Q_ANGLE_RST =
		CFG_W'(((64'd1 << COV_FRAC) + 64'd500) / 64'd1000);
	localparam logic [CFG_W-1:0] Q_BIAS_RST =
		CFG_W'((((64'd1 << COV_FRAC) * 64'd3) + 64'd500) / 64'd1000);
	localparam logic [CFG_W-1:0] R_MEAS_RST =
		CFG_W'((((64'd1 << COV_FRAC) * 64'd3) + 64'd50) / 64'd100);
	localparam logic signed [PROD_W-1:0] HALF_DT =
		{{(PROD_W-1){1'b0}}, 1'b1} << (DT_FRAC-1);
	localparam logic signed [PROD_W-1:0] HALF_CV =
		{{(PROD_W-1){1'b0}}, 1'b1} << (COV_FRAC-1);

	logic [CFG_W-1:0] q_angle_q, q_bias_q, r_meas_q;
	logic [DATA_W-1:0] meas_q, rate_q, angle_q, bias_q;
	logic [DATA_W-1:0] c00_q, c01_q, c10_q, c11_q, p00_q, p01_q, k0_q, k1_q;
	logic [DT_W-1:0] dt_q;
	logic [MUL_W-1:0] inner_q;
	logic [DATA_W:0] y_q;
	logic neg0_q, neg1_q, zero_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic out_valid_q;
	logic [DATA_W-1:0] out_angle_q, out_rate_q;

	logic signed [MUL_W-1:0] op_a, op_b;
	logic signed [PROD_W-1:0] sum_dt, sum_cv, shr_dt, shr_cv;
	logic signed [SUM_W-1:0] rnd;
	logic signed [DATA_W+1:0] s_ext;
	logic [DEN_W-1:0] s_mag;
	logic [DATA_W-1:0] pm0, pm1;
	logic [NUM_W-1:0] quo0, quo1;

	function automatic logic [MUL_W-1:0] ext32(input logic [DATA_W-1:0] v);
		return {{(MUL_W-DATA_W){v[DATA_W-1]}}, v};
	endfunction

	function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
		return v[DATA_W-1] ? DATA_W'(-v) : v;
	endfunction

	function automatic logic [DATA_W-1:0] to_gain(input logic [NUM_W-1:0] q,
		input logic neg, input logic zero);
		logic [DATA_W:0] qc;
		logic signed [SUM_W-1:0] k;
		qc = (|q[NUM_W-1:DATA_W-1]) ? {2'b01, {(DATA_W-1){1'b0}}} : q[DATA_W:0];
		k = neg ? -$signed({{(SUM_W-DATA_W-1){1'b0}}, qc})
			: $signed({{(SUM_W-DATA_W-1){1'b0}}, qc});
		return zero ? '0 : sat32(k);
	endfunction

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (cmd.sel)
			P_DT_RATE:  begin op_a = {{(MUL_W-DT_W){1'b0}}, dt_q}; op_b = ext32(rate_q); end
			P_DT_P11:   begin op_a = {{(MUL_W-DT_W){1'b0}}, dt_q}; op_b = ext32(c11_q); end
			P_DT_INNER: begin op_a = {{(MUL_W-DT_W){1'b0}}, dt_q}; op_b = inner_q; end
			P_DT_QBIAS: begin
				op_a = {{(MUL_W-DT_W){1'b0}}, dt_q};
				op_b = {{(MUL_W-CFG_W){1'b0}}, q_bias_q};
			end
			P_K0_Y:     begin op_a = ext32(k0_q); op_b = {{(MUL_W-DATA_W-1){y_q[DATA_W]}}, y_q}; end
			P_K1_Y:     begin op_a = ext32(k1_q); op_b = {{(MUL_W-DATA_W-1){y_q[DATA_W]}}, y_q}; end
			P_K0_P00:   begin op_a = ext32(k0_q); op_b = ext32(p00_q); end
			P_K0_P01:   begin op_a = ext32(k0_q); op_b = ext32(p01_q); end
			P_K1_P00:   begin op_a = ext32(k1_q); op_b = ext32(p00_q); end
			P_K1_P01:   begin op_a = ext32(k1_q); op_b = ext32(p01_q); end
			default:    begin op_a = '0; op_b = '0; end
		endcase
	end

	always_comb begin
		sum_dt = prod_s1 + (prod_s1[PROD_W-1] ? HALF_DT - 1 : HALF_DT);
		sum_cv = prod_s1 + (prod_s1[PROD_W-1] ? HALF_CV - 1 : HALF_CV);
		shr_dt = sum_dt >>> DT_FRAC;
		shr_cv = sum_cv >>> COV_FRAC;
		case (cmd.sel) inside
			P_DT_RATE, P_DT_P11, P_DT_INNER, P_DT_QBIAS: rnd = shr_dt[SUM_W-1:0];
			default: rnd = shr_cv[SUM_W-1:0];
		endcase
	end

	always_comb begin
		s_ext = {{2{c00_q[DATA_W-1]}}, c00_q} + {3'b000, r_meas_q};
		s_mag = s_ext[DATA_W+1] ? DEN_W'(-s_ext) : s_ext[DEN_W-1:0];
		pm0 = mag32(c00_q);
		pm1 = mag32(c10_q);
	end

	abkf_div #(.COV_FRAC(COV_FRAC)) u_div0 (
		.clk  (clk),
		.ld   (cmd.div_ld),
		.step (cmd.div_step),
		.num  (pm0),
		.den  (s_mag),
		.quo  (quo0)
	);

	abkf_div #(.COV_FRAC(COV_FRAC)) u_div1 (
		.clk  (clk),
		.ld   (cmd.div_ld),
		.step (cmd.div_step),
		.num  (pm1),
		.den  (s_mag),
		.quo  (quo1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_angle_q <= Q_ANGLE_RST;
			q_bias_q  <= Q_BIAS_RST;
			r_meas_q  <= R_MEAS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_Q_ANGLE: q_angle_q <= cfg_data;
				REG_Q_BIAS:  q_bias_q  <= cfg_data;
				REG_R_NOISE: r_meas_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			bias_q  <= '0;
			c00_q   <= '0;
			c01_q   <= '0;
			c10_q   <= '0;
			c11_q   <= '0;
		end else begin
			if (cmd.load && cmd.preset) begin
				angle_q <= meas;
			end
			if (cmd.wb) begin
				case (cmd.sel) inside
					P_DT_RATE, P_K0_Y: angle_q <= sat32(sx(angle_q) + rnd);
					P_DT_P11: begin
						c01_q <= sat32(sx(c01_q) - rnd);
						c10_q <= sat32(sx(c10_q) - rnd);
					end
					P_DT_INNER: c00_q <= sat32(sx(c00_q) + rnd);
					P_DT_QBIAS: c11_q <= sat32(sx(c11_q) + rnd);
					P_K1_Y:     bias_q <= sat32(sx(bias_q) + rnd);
					P_K0_P00:   c00_q <= sat32(sx(c00_q) - rnd);
					P_K0_P01:   c01_q <= sat32(sx(c01_q) - rnd);
					P_K1_P00:   c10_q <= sat32(sx(c10_q) - rnd);
					P_K1_P01:   c11_q <= sat32(sx(c11_q) - rnd);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			meas_q <= meas;
			dt_q   <= dt;
			rate_q <= sat32(sx(gyro) - sx(bias_q));
		end
		if (cmd.mul) begin
			prod_s1 <= op_a * op_b;
		end
		if (cmd.wb && cmd.sel == P_DT_P11) begin
			inner_q <= MUL_W'(rnd - sx(c01_q) - sx(c10_q)
				+ $signed({{(SUM_W-CFG_W){1'b0}}, q_angle_q}));
		end
		if (cmd.div_ld) begin
			y_q    <= (DATA_W+1)'(sx(meas_q) - sx(angle_q));
			p00_q  <= c00_q;
			p01_q  <= c01_q;
			neg0_q <= c00_q[DATA_W-1] ^ s_ext[DATA_W+1];
			neg1_q <= c10_q[DATA_W-1] ^ s_ext[DATA_W+1];
			zero_q <= (s_mag == '0);
		end
		if (cmd.gain_ld) begin
			k0_q <= to_gain(quo0, neg0_q, zero_q);
			k1_q <= to_gain(quo1, neg1_q, zero_q);
		end
		if (cmd.out_ld) begin
			out_angle_q <= angle_q;
			out_rate_q  <= rate_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_full = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign out_angle = out_angle_q;
	assign out_rate  = out_rate_q;

endmodule

>>> sv/abkf_ctrl.sv
module abkf_ctrl #(
	parameter int COV_FRAC = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_opcode,
	output logic                in_ready,
	input  abkf_pkg::status_t   status,
	output abkf_pkg::cmd_t      cmd
);
	import abkf_pkg::*;

	localparam int DIV_STEPS = (32 + COV_FRAC + 1) / 2;
	localparam int CNT_W = $clog2(DIV_STEPS);

	state_t state_q, state_d;
	prod_t sel_q;
	logic [CNT_W-1:0] cnt_q;
	logic div_last;

	assign div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_opcode == OP_PRESET) ? ST_DONE : ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_WB;
			ST_WB: begin
				if (sel_q == P_DT_QBIAS) begin
					state_d = ST_DIV;
				end else if (sel_q == P_K1_P01) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_DIV:  state_d = div_last ? ST_GAIN : ST_DIV;
			ST_GAIN: state_d = ST_MUL;
			ST_DONE: state_d = status.out_full ? ST_DONE : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.sel = sel_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				cmd.preset = in_valid && (in_opcode == OP_PRESET);
			end
			ST_MUL:  cmd.mul = 1'b1;
			ST_WB: begin
				cmd.wb = 1'b1;
				cmd.div_ld = (sel_q == P_DT_QBIAS);
			end
			ST_DIV:  cmd.div_step = 1'b1;
			ST_GAIN: cmd.gain_ld = 1'b1;
			ST_DONE: cmd.out_ld = !status.out_full;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= P_DT_RATE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				sel_q <= P_DT_RATE;
				cnt_q <= '0;
			end else if (state_q == ST_WB && sel_q != P_K1_P01) begin
				sel_q <= prod_t'(sel_q + 4'd1);
			end
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule
